### design/fuzzy_subsequence_score_defines.svh
// assertion helpers shared by the scorer
`ifndef FUZZY_SUBSEQUENCE_SCORE_DEFINES_SVH
`define FUZZY_SUBSEQUENCE_SCORE_DEFINES_SVH

// invariant that holds on every clock edge out of reset
`define FSS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition implies consequence in the same cycle
`define FSS_ASSERT_IMPLY(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

### design/fss_pkg.sv
package fss_pkg;

  localparam int MAX_NEEDLE_DEF   = 64;
  localparam int PREFIX_SCALE_DEF = 2;

  localparam int CH_W       = 21;
  localparam int BONUS_W    = 8;
  localparam int START_W    = 16;
  localparam int SCORE_W    = 16;
  localparam int TRACK_W    = 24;
  localparam int GAIN0_W    = 12;
  localparam int GAIN_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [TRACK_W-1:0] TRACK_MAX = 24'hFFFFFF;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_SCORE      = 3'd0,
    REG_GAP_START        = 3'd1,
    REG_GAP_EXTEND       = 3'd2,
    REG_CONSEC_BONUS     = 3'd3,
    REG_FIRST_MULT       = 3'd4,
    REG_MAX_PREFIX_BONUS = 3'd5,
    REG_PREFER_PREFIX    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_NEEDLE = 1'b0,
    OP_COLUMN = 1'b1
  } op_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic load;
    logic restart;
    logic col;
    logic col_last;
  } cell_ctrl_t;

  // column data and gains shared by all cells
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [GAIN0_W-1:0] first_gain;
    logic [GAIN_W-1:0]  cons_gain;
    logic [GAIN_W-1:0]  gap_gain;
    logic [GAIN_W-1:0]  gap_open;
    logic [7:0]         gap_ext;
  } col_data_t;

  // end-of-window record handed to the result pipeline
  typedef struct packed {
    logic [TRACK_W-1:0] best;
    logic [START_W-1:0] start;
    logic               ovf;
  } res_item_t;

  typedef struct packed {
    logic [7:0] open_pen;
    logic [7:0] gap_extend;
    logic [7:0] max_prefix;
    logic       prefer;
  } prefix_cfg_t;

endpackage

### design/fss_cell.sv
module fss_cell import fss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  col_data_t          col,
  input  logic               head,
  input  logic [TRACK_W-1:0] up_match,
  input  logic               up_active,
  input  logic               dn_active,
  output logic [TRACK_W-1:0] match,
  output logic               active,
  output logic [TRACK_W-1:0] fin
);

  logic [CH_W-1:0]    needle_ch;
  logic [TRACK_W-1:0] gap;

  logic               we;
  logic               eq;
  logic               last_row;
  logic [TRACK_W:0]   cand_cons;
  logic [TRACK_W:0]   cand_gap;
  logic [TRACK_W:0]   nh_wide;
  logic [TRACK_W-1:0] nh;
  logic [TRACK_W-1:0] nc_open;
  logic [TRACK_W-1:0] nc_ext;
  logic [TRACK_W-1:0] nc;

  always_comb begin
    // write slot is the first empty cell, or cell 0 when a new needle starts
    we = ctrl.load & (ctrl.restart ? head : (~active & up_active));
    eq = (col.ch == needle_ch);

    cand_cons = (eq && up_match != '0) ?
                {1'b0, up_match} + (TRACK_W+1)'(col.cons_gain) : '0;
    cand_gap  = (eq && gap != '0) ?
                {1'b0, gap} + (TRACK_W+1)'(col.gap_gain) : '0;

    if (head) begin
      nh_wide = eq ? (TRACK_W+1)'(col.first_gain) : '0;
    end else begin
      nh_wide = (cand_cons > cand_gap) ? cand_cons : cand_gap;
    end
    nh = nh_wide[TRACK_W] ? TRACK_MAX : nh_wide[TRACK_W-1:0];

    nc_open = (up_match > TRACK_W'(col.gap_open)) ?
              up_match - TRACK_W'(col.gap_open) : '0;
    nc_ext  = (gap > TRACK_W'(col.gap_ext)) ? gap - TRACK_W'(col.gap_ext) : '0;
    if (head) begin
      nc = '0;
    end else begin
      nc = (nc_ext > nc_open) ? nc_ext : nc_open;
    end

    last_row = active & ~dn_active;
    fin      = (ctrl.col && last_row) ? nh : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      match  <= '0;
      gap    <= '0;
    end else if (ctrl.load) begin
      active <= ctrl.restart ? head : (active | we);
      match  <= '0;
      gap    <= '0;
    end else if (ctrl.col) begin
      if (ctrl.col_last || !active) begin
        match <= '0;
        gap   <= '0;
      end else begin
        match <= nh;
        gap   <= nc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      needle_ch <= col.ch;
    end
  end

endmodule

### design/fss_result.sv
module fss_result import fss_pkg::*; #(
  parameter int PREFIX_SCALE = PREFIX_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  prefix_cfg_t        cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  res_item_t          item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [SCORE_W-1:0] score,
  output logic               needle_too_long
);

  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = SCORE_W + RECIP_SHIFT + 1;
  localparam int BASE_W      = 8 + $clog2(PREFIX_SCALE) + 1;
  localparam logic [RECIP_SHIFT:0] RECIP =
    (RECIP_SHIFT+1)'((1 << RECIP_SHIFT) / PREFIX_SCALE);
  localparam logic [SCORE_W-1:0] SCALE16 = SCORE_W'(PREFIX_SCALE);

  logic v1, v2, v3, v4, v5, v6;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  res_item_t s1_item;

  logic               s2_found, s2_zero, s2_ovf;
  logic [SCORE_W-1:0] s2_s16;
  logic [TRACK_W-1:0] s2_ext_prod;

  logic               s3_found, s3_zero, s3_ovf;
  logic [SCORE_W-1:0] s3_s16, s3_raw;

  logic               s4_found, s4_zero, s4_ovf;
  logic [SCORE_W-1:0] s4_s16, s4_raw, s4_q0;

  logic               s5_found, s5_zero, s5_ovf;
  logic [SCORE_W-1:0] s5_s16, s5_q;

  logic [START_W-1:0] start_m1;
  logic [TRACK_W-1:0] ext_prod;
  logic [SCORE_W-1:0] ext;
  logic [BASE_W-1:0]  base_scaled;
  logic [BASE_W-1:0]  base;
  logic [SCORE_W-1:0] base16;
  logic [SCORE_W-1:0] raw;
  logic [PROD_W-1:0]  recip_prod;
  logic [SCORE_W-1:0] qd;
  logic [SCORE_W-1:0] rem;
  logic [SCORE_W-1:0] q;
  logic [SCORE_W-1:0] pb;
  logic [SCORE_W:0]   sum;
  logic [SCORE_W-1:0] total;

  // bubble-collapsing ready chain
  always_comb begin
    adv6 = ~v6 | out_ready;
    adv5 = ~v5 | adv6;
    adv4 = ~v4 | adv5;
    adv3 = ~v3 | adv4;
    adv2 = ~v2 | adv3;
    adv1 = ~v1 | adv2;
    item_ready = adv1;
  end

  always_comb begin
    start_m1 = s1_item.start - START_W'(1);
    ext_prod = TRACK_W'(start_m1) * TRACK_W'(cfg.gap_extend);

    ext         = (s2_ext_prod > TRACK_W'(SCORE_MAX)) ? SCORE_MAX : s2_ext_prod[SCORE_W-1:0];
    base_scaled = BASE_W'(cfg.max_prefix) * BASE_W'(PREFIX_SCALE);
    base        = (base_scaled > BASE_W'(cfg.open_pen)) ?
                  base_scaled - BASE_W'(cfg.open_pen) : '0;
    base16      = SCORE_W'(base);
    raw         = (base16 > ext) ? base16 - ext : '0;

    // divide by the scale through a reciprocal, then one correction step
    recip_prod = PROD_W'(s3_raw) * PROD_W'(RECIP);

    qd  = s4_q0 * SCALE16;
    rem = s4_raw - qd;
    q   = (rem >= SCALE16) ? s4_q0 + SCORE_W'(1) : s4_q0;

    pb    = s5_zero ? SCORE_W'(cfg.max_prefix) : s5_q;
    sum   = {1'b0, s5_s16} + (cfg.prefer ? {1'b0, pb} : '0);
    total = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (adv1) v1 <= item_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
      if (adv6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_item <= item;
    end
    if (adv2) begin
      s2_found    <= (s1_item.best != '0);
      s2_s16      <= s1_item.best[SCORE_W-1:0] - SCORE_W'(1);
      s2_zero     <= (s1_item.start == '0);
      s2_ovf      <= s1_item.ovf;
      s2_ext_prod <= ext_prod;
    end
    if (adv3) begin
      s3_found <= s2_found;
      s3_s16   <= s2_s16;
      s3_zero  <= s2_zero;
      s3_ovf   <= s2_ovf;
      s3_raw   <= raw;
    end
    if (adv4) begin
      s4_found <= s3_found;
      s4_s16   <= s3_s16;
      s4_zero  <= s3_zero;
      s4_ovf   <= s3_ovf;
      s4_raw   <= s3_raw;
      s4_q0    <= recip_prod[RECIP_SHIFT +: SCORE_W];
    end
    if (adv5) begin
      s5_found <= s4_found;
      s5_s16   <= s4_s16;
      s5_zero  <= s4_zero;
      s5_ovf   <= s4_ovf;
      s5_q     <= q;
    end
    if (adv6) begin
      found           <= s5_found;
      score           <= s5_found ? total : '0;
      needle_too_long <= s5_ovf;
    end
  end

  assign out_valid = v6;

endmodule

### design/fuzzy_subsequence_score.sv
// fuzzy subsequence scorer
//
// config port: cfg_write with cfg_index/cfg_data writes one register per cycle, no
// read-back; write only while no item is in flight
// input channel (in_valid/in_ready): operation selects a needle character load or
// a haystack column; last closes the needle or the window
// output channel (out_valid/out_ready): one item per window, on its last column
//
// one needle row per cell; a column updates every row in parallel from the row
// above, so the cell row takes one item per clock, back to back, while in_ready is high
// the record of a window enters a six-stage result pipeline for the prefix bonus
// when its last column is taken; out_valid comes from the last stage
// stalls: the result pipeline collapses bubbles, so up to six finished items
// queue behind a stalled receiver; in_ready drops only when all six are full
// reset: registers return to defaults, the needle is empty and both tracks are
// clear; no clearing pass is needed, the first item can arrive next cycle
`include "fuzzy_subsequence_score_defines.svh"

module fuzzy_subsequence_score import fss_pkg::*; #(
  parameter int MAX_NEEDLE   = MAX_NEEDLE_DEF,
  parameter int PREFIX_SCALE = PREFIX_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [CH_W-1:0]       ch,
  input  logic [BONUS_W-1:0]    bonus,
  input  logic [START_W-1:0]    window_start,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [SCORE_W-1:0]    score,
  output logic                  needle_too_long
);

  // configuration registers
  logic [7:0] match_score;
  logic [7:0] gap_open_penalty;
  logic [7:0] gap_extend_penalty;
  logic [7:0] consecutive_bonus;
  logic [3:0] first_char_multiplier;
  logic [7:0] max_prefix_bonus;
  logic       prefix_enable;

  // needle bookkeeping and running best of the final row
  logic               needle_complete;
  logic               needle_overflow;
  logic [TRACK_W-1:0] best;

  logic               in_acc;
  cell_ctrl_t         ctrl;
  col_data_t          col;
  logic [GAIN0_W-1:0] first_prod;
  logic [7:0]         cons_max;

  logic [MAX_NEEDLE-1:0] active_vec;
  logic [MAX_NEEDLE-1:0] last_row_vec;
  logic [TRACK_W-1:0]    match_arr [MAX_NEEDLE];
  logic [TRACK_W-1:0]    fin_arr   [MAX_NEEDLE];
  logic [TRACK_W-1:0]    fin_or;
  logic [TRACK_W-1:0]    best_new;

  res_item_t   res_item;
  prefix_cfg_t pcfg;
  logic        res_valid;
  logic        res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_score           <= 8'd16;
      gap_open_penalty      <= 8'd3;
      gap_extend_penalty    <= 8'd1;
      consecutive_bonus     <= 8'd4;
      first_char_multiplier <= 4'd2;
      max_prefix_bonus      <= 8'd8;
      prefix_enable         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MATCH_SCORE:      match_score           <= cfg_data;
        REG_GAP_START:        gap_open_penalty      <= cfg_data;
        REG_GAP_EXTEND:       gap_extend_penalty    <= cfg_data;
        REG_CONSEC_BONUS:     consecutive_bonus     <= cfg_data;
        REG_FIRST_MULT:       first_char_multiplier <= cfg_data[3:0];
        REG_MAX_PREFIX_BONUS: max_prefix_bonus      <= cfg_data;
        REG_PREFER_PREFIX:    prefix_enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item accept and the broadcast to the cell row
  assign in_ready = res_ready;
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    ctrl.load     = in_acc & (operation == OP_NEEDLE);
    ctrl.col      = in_acc & (operation == OP_COLUMN);
    ctrl.restart  = needle_complete;
    ctrl.col_last = last;

    // gains that do not depend on the row are formed once per column
    first_prod     = GAIN0_W'(bonus) * GAIN0_W'(first_char_multiplier);
    cons_max       = (bonus > consecutive_bonus) ? bonus : consecutive_bonus;
    col.ch         = ch;
    col.first_gain = first_prod + GAIN0_W'(match_score) + GAIN0_W'(1);
    col.cons_gain  = GAIN_W'(cons_max) + GAIN_W'(match_score);
    col.gap_gain   = GAIN_W'(bonus) + GAIN_W'(match_score) + GAIN_W'(1);
    col.gap_open   = GAIN_W'(gap_open_penalty) + GAIN_W'(1);
    col.gap_ext    = gap_extend_penalty;
  end

  // the row of cells: each holds one needle character and its two tracks,
  // and reads the old match track of the cell above
  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
    logic [TRACK_W-1:0] up_m;
    logic               up_a;
    logic               dn_a;

    if (k == 0) begin : g_top
      assign up_m = '0;
      assign up_a = 1'b1;
    end else begin : g_mid
      assign up_m = match_arr[k-1];
      assign up_a = active_vec[k-1];
    end

    if (k == MAX_NEEDLE - 1) begin : g_end
      assign dn_a = 1'b0;
    end else begin : g_link
      assign dn_a = active_vec[k+1];
    end

    fss_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .col       (col),
      .head      (k == 0),
      .up_match  (up_m),
      .up_active (up_a),
      .dn_active (dn_a),
      .match     (match_arr[k]),
      .active    (active_vec[k]),
      .fin       (fin_arr[k])
    );
  end

  // only the final loaded row drives its value, so an or picks it out
  always_comb begin
    fin_or = '0;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      fin_or = fin_or | fin_arr[k];
    end
    best_new     = (fin_or > best) ? fin_or : best;
    last_row_vec = active_vec & ~(active_vec >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_complete <= 1'b0;
      needle_overflow <= 1'b0;
      best            <= '0;
    end else if (ctrl.load) begin
      // a load after a finished needle starts over from row 0
      needle_complete <= last;
      needle_overflow <= needle_complete ? 1'b0 :
                         (needle_overflow | active_vec[MAX_NEEDLE-1]);
      best            <= '0;
    end else if (ctrl.col) begin
      best <= last ? '0 : best_new;
    end
  end

  // end of window: hand the record to the result pipeline
  always_comb begin
    res_valid      = ctrl.col & last;
    res_item.best  = best_new;
    res_item.start = window_start;
    res_item.ovf   = needle_overflow;

    pcfg.open_pen   = gap_open_penalty;
    pcfg.gap_extend = gap_extend_penalty;
    pcfg.max_prefix = max_prefix_bonus;
    pcfg.prefer     = prefix_enable;
  end

  fss_result #(
    .PREFIX_SCALE (PREFIX_SCALE)
  ) u_result (
    .clk             (clk),
    .rst             (rst),
    .cfg             (pcfg),
    .item_valid      (res_valid),
    .item_ready      (res_ready),
    .item            (res_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .score           (score),
    .needle_too_long (needle_too_long)
  );

  // loaded rows form one unbroken run from row 0
  `FSS_ASSERT_ALWAYS(a_rows_contiguous, ((active_vec >> 1) & ~active_vec) == '0, "needle rows not contiguous")
  // at most one row can be the final row
  `FSS_ASSERT_ALWAYS(a_one_final_row, $onehot0(last_row_vec), "more than one final needle row")
  // dropped characters only once every row is filled
  `FSS_ASSERT_IMPLY(a_overflow_full, needle_overflow, active_vec[MAX_NEEDLE-1], "overflow with free rows")

endmodule
